@@ sv/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BVP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define BVP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bvp_pkg.sv @@
// ----------------------------------------------------------------------------
// bvp_pkg
// types, constants and fixed-point helpers for the boris velocity push
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bvp_pkg;

    localparam int QW              = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int DIV_W           = 49;   // width of numerator and divisor
    localparam int REM_W           = 66;   // divisor shifted by the top quotient bit
    localparam int QUOT_W          = 18;   // factor lies in [0, 2^17]
    localparam int APB_AW          = 3;

    localparam logic REG_CTM = 1'b0;
    localparam logic REG_TS  = 1'b1;

    typedef logic [2:0][QW-1:0] vec_t;

    // vel in the lowest bits, x lowest within each vector
    typedef struct packed {
        vec_t bfield;
        vec_t efield;
        vec_t vel;
    } item_t;

    typedef struct packed {
        vec_t vm;
        vec_t vp;
        vec_t t;
        vec_t ek;
    } div_ctx_t;

    function automatic logic signed [63:0] smul(logic [QW-1:0] a, logic [QW-1:0] b);
        return $signed(a) * $signed(b);
    endfunction

    // round half up, drop 16 fraction bits
    function automatic logic signed [47:0] rnd(logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd32768;
        return s[63:16];
    endfunction

    function automatic logic [QW-1:0] sat32(logic signed [51:0] x);
        logic [QW-1:0] r;
        if (x > 52'sd2147483647)
            r = 32'h7fff_ffff;
        else if (x < -52'sd2147483648)
            r = 32'h8000_0000;
        else
            r = x[QW-1:0];
        return r;
    endfunction

endpackage

@@ sv/bvp_front.sv @@
// ----------------------------------------------------------------------------
// bvp_front
// input stage: takes particle transactions and hands them to the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvp_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [287:0]   s_tdata,
    output logic           push,
    output bvp_pkg::item_t push_item,
    input  logic           q_full
);
    import bvp_pkg::*;

    logic  fv_reg;
    logic  fv_next;
    item_t item_reg;

    assign s_tready  = !fv_reg || !q_full;
    assign push      = fv_reg && !q_full;
    assign push_item = item_reg;

    always_comb
    begin
        fv_next = fv_reg;
        if (s_tvalid && s_tready)
            fv_next = 1'b1;
        else if (push)
            fv_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else
            fv_reg <= fv_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= item_t'(s_tdata);
    end

endmodule

@@ sv/bvp_queue.sv @@
// ----------------------------------------------------------------------------
// bvp_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bvp_queue #(
    parameter int DEPTH = bvp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bvp_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output bvp_pkg::item_t head_item
);
    import bvp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

    `BVP_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "queue count past depth")
    `BVP_ASSERT_NEXT(a_pop_nonempty, clk, rst_n, pop && !push, count_reg == $past(count_reg) - 1'b1, "queue pop miscounted")

endmodule

@@ sv/bvp_div.sv @@
// ----------------------------------------------------------------------------
// bvp_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bvp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [bvp_pkg::DIV_W-1:0]   num,
    input  logic [bvp_pkg::DIV_W-1:0]   den,
    input  bvp_pkg::div_ctx_t           in_ctx,
    output logic                        out_valid,
    output logic [bvp_pkg::QUOT_W-1:0]  quot,
    output bvp_pkg::div_ctx_t           out_ctx
);
    import bvp_pkg::*;

    logic              vld_c [QUOT_W+1];
    logic [REM_W-1:0]  rem_c [QUOT_W+1];
    logic [DIV_W-1:0]  den_c [QUOT_W+1];
    logic [QUOT_W-1:0] q_c   [QUOT_W+1];
    div_ctx_t          ctx_c [QUOT_W+1];

    assign vld_c[0] = in_valid;
    assign rem_c[0] = REM_W'(num);
    assign den_c[0] = den;
    assign q_c[0]   = '0;
    assign ctx_c[0] = in_ctx;

    for (genvar g = 0; g < QUOT_W; g++)
    begin : g_stage
        logic              vld_reg;
        logic [REM_W-1:0]  rem_reg, rem_next;
        logic [DIV_W-1:0]  den_reg;
        logic [QUOT_W-1:0] q_reg, q_next;
        div_ctx_t          ctx_reg;
        logic [REM_W-1:0]  shifted;

        // trial subtract of the divisor at quotient bit QUOT_W-1-g
        always_comb
        begin
            shifted  = REM_W'(den_c[g]) << (QUOT_W - 1 - g);
            rem_next = rem_c[g];
            q_next   = q_c[g];
            if (rem_c[g] >= shifted)
            begin
                rem_next                 = rem_c[g] - shifted;
                q_next[QUOT_W - 1 - g]   = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (adv)
                vld_reg <= vld_c[g];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg <= rem_next;
                den_reg <= den_c[g];
                q_reg   <= q_next;
                ctx_reg <= ctx_c[g];
            end
        end

        assign vld_c[g+1] = vld_reg;
        assign rem_c[g+1] = rem_reg;
        assign den_c[g+1] = den_reg;
        assign q_c[g+1]   = q_reg;
        assign ctx_c[g+1] = ctx_reg;
    end

    assign out_valid = vld_c[QUOT_W];
    assign quot      = q_c[QUOT_W];
    assign out_ctx   = ctx_c[QUOT_W];

    `BVP_ASSERT(a_rem_below_den, clk, rst_n, !out_valid || (rem_c[QUOT_W] < REM_W'(den_c[QUOT_W])), "divider remainder not below divisor")

endmodule

@@ sv/bvp_back.sv @@
// ----------------------------------------------------------------------------
// bvp_back
// arithmetic pipeline: kicks, rotation, factor division, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bvp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          k,
    input  logic                 q_valid,
    input  bvp_pkg::item_t       q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [95:0]          m_tdata
);
    import bvp_pkg::*;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic [7:0] vld_vec;

    // stage 1: k*E and k*B products
    logic signed [63:0] s1_pe_reg [3];
    logic signed [63:0] s1_pb_reg [3];
    vec_t               s1_v_reg;
    // stage 2: ek, t, v-
    vec_t ek_c, t_c, vm_c;
    vec_t s2_ek_reg, s2_t_reg, s2_vm_reg;
    // stage 3: v- x t and t.t products
    logic signed [63:0] s3_pa_reg [3];
    logic signed [63:0] s3_pb_reg [3];
    logic signed [63:0] s3_sq_reg [3];
    vec_t               s3_ek_reg, s3_t_reg, s3_vm_reg;
    // stage 4: v', divisor and numerator
    vec_t               vp_c;
    logic signed [48:0] c1_c [3];
    logic [DIV_W-1:0]   dot_c, d_c, num_c;
    logic [DIV_W-1:0]   s4_num_reg, s4_d_reg;
    div_ctx_t           s4_ctx_reg, s4_ctx_c;
    // divider output
    logic               dv;
    logic [QUOT_W-1:0]  f;
    div_ctx_t           dctx;
    // stage 5: t*f
    logic signed [50:0] s5_ps_reg [3];
    div_ctx_t           s5_ctx_reg;
    // stage 6: s
    vec_t               s_c;
    vec_t               s6_s_reg, s6_vp_reg, s6_vm_reg, s6_ek_reg;
    // stage 7: v' x s products
    logic signed [63:0] s7_pa_reg [3];
    logic signed [63:0] s7_pb_reg [3];
    vec_t               s7_vm_reg, s7_ek_reg;
    // stage 8: output
    logic signed [48:0] c2_c [3];
    vec_t               vplus_c, nv_c, out_reg;

    assign adv      = !v8_reg || m_tready;
    assign q_pop    = adv && q_valid;
    assign m_tvalid = v8_reg;
    assign m_tdata  = out_reg;
    assign vld_vec  = {v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= dv;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ek_c[i] = sat32(52'(rnd(s1_pe_reg[i])));
            t_c[i]  = sat32(52'(rnd(s1_pb_reg[i])));
            vm_c[i] = sat32(52'($signed(s1_v_reg[i])) + 52'($signed(ek_c[i])));
        end
    end

    // v' = v- + v- x t ; d = 1 + t.t ; numerator 2 + d/2
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c1_c[i] = 49'(rnd(s3_pa_reg[i])) - 49'(rnd(s3_pb_reg[i]));
            vp_c[i] = sat32(52'($signed(s3_vm_reg[i])) + 52'(c1_c[i]));
        end
        dot_c = DIV_W'(rnd(s3_sq_reg[0])) + DIV_W'(rnd(s3_sq_reg[1]))
              + DIV_W'(rnd(s3_sq_reg[2]));
        d_c   = dot_c + (DIV_W'(1) << 16);
        num_c = (DIV_W'(1) << 33) + (d_c >> 1);
        s4_ctx_c.vm = s3_vm_reg;
        s4_ctx_c.vp = vp_c;
        s4_ctx_c.t  = s3_t_reg;
        s4_ctx_c.ek = s3_ek_reg;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s_c[i] = sat32(52'(rnd(64'(s5_ps_reg[i]))));
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c2_c[i]    = 49'(rnd(s7_pa_reg[i])) - 49'(rnd(s7_pb_reg[i]));
            vplus_c[i] = sat32(52'($signed(s7_vm_reg[i])) + 52'(c2_c[i]));
            nv_c[i]    = sat32(52'($signed(vplus_c[i])) + 52'($signed(s7_ek_reg[i])));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_pe_reg[i] <= smul(q_item.efield[i], k);
                s1_pb_reg[i] <= smul(q_item.bfield[i], k);
                s3_sq_reg[i] <= smul(s2_t_reg[i], s2_t_reg[i]);
                s5_ps_reg[i] <= $signed(dctx.t[i]) * $signed({1'b0, f});
            end
            s1_v_reg  <= q_item.vel;
            s2_ek_reg <= ek_c;
            s2_t_reg  <= t_c;
            s2_vm_reg <= vm_c;

            s3_pa_reg[0] <= smul(s2_vm_reg[1], s2_t_reg[2]);
            s3_pb_reg[0] <= smul(s2_vm_reg[2], s2_t_reg[1]);
            s3_pa_reg[1] <= smul(s2_vm_reg[2], s2_t_reg[0]);
            s3_pb_reg[1] <= smul(s2_vm_reg[0], s2_t_reg[2]);
            s3_pa_reg[2] <= smul(s2_vm_reg[0], s2_t_reg[1]);
            s3_pb_reg[2] <= smul(s2_vm_reg[1], s2_t_reg[0]);
            s3_ek_reg    <= s2_ek_reg;
            s3_t_reg     <= s2_t_reg;
            s3_vm_reg    <= s2_vm_reg;

            s4_num_reg <= num_c;
            s4_d_reg   <= d_c;
            s4_ctx_reg <= s4_ctx_c;

            s5_ctx_reg <= dctx;

            s6_s_reg  <= s_c;
            s6_vp_reg <= s5_ctx_reg.vp;
            s6_vm_reg <= s5_ctx_reg.vm;
            s6_ek_reg <= s5_ctx_reg.ek;

            s7_pa_reg[0] <= smul(s6_vp_reg[1], s6_s_reg[2]);
            s7_pb_reg[0] <= smul(s6_vp_reg[2], s6_s_reg[1]);
            s7_pa_reg[1] <= smul(s6_vp_reg[2], s6_s_reg[0]);
            s7_pb_reg[1] <= smul(s6_vp_reg[0], s6_s_reg[2]);
            s7_pa_reg[2] <= smul(s6_vp_reg[0], s6_s_reg[1]);
            s7_pb_reg[2] <= smul(s6_vp_reg[1], s6_s_reg[0]);
            s7_vm_reg    <= s6_vm_reg;
            s7_ek_reg    <= s6_ek_reg;

            out_reg <= nv_c;
        end
    end

    bvp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v4_reg),
        .num       (s4_num_reg),
        .den       (s4_d_reg),
        .in_ctx    (s4_ctx_reg),
        .out_valid (dv),
        .quot      (f),
        .out_ctx   (dctx)
    );

    `BVP_ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(vld_vec), "pipeline moved while stalled")
    `BVP_ASSERT_NEXT(a_pop_enters, clk, rst_n, q_pop, v1_reg, "popped transaction lost at stage one")

endmodule

@@ sv/boris_velocity_push.sv @@
// throughput: one transaction per cycle while the output is not stalled, set by the fully pipelined back end
//   (up to 9 multipliers per product stage and an 18-stage divider, one bit a stage)
// a stalled output stops the back end; the 4-entry queue and input register
//   keep taking transactions until full
// reset: rst_n async active low clears valids, queue and registers (k = 0)
// ----------------------------------------------------------------------------
// boris_velocity_push
// boris particle velocity push in q16.16, streaming in and out, apb config
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module boris_velocity_push #(
    parameter int QUEUE_DEPTH = bvp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // apb config port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bvp_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // vel_x, vel_y, vel_z, efield_x, efield_y, efield_z, bfield_x, bfield_y, bfield_z
    input  logic [287:0]              s_tdata,
    // output stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // new_vel_x, new_vel_y, new_vel_z
    output logic [95:0]               m_tdata
);
    import bvp_pkg::*;

    logic [31:0]        ctm_reg;     // charge over mass, signed q16.16
    logic [31:0]        ts_reg;      // time step, unsigned q0.32
    logic signed [64:0] prod_reg;
    logic signed [65:0] ksum;
    logic [31:0]        k_reg;
    logic               wr_en;

    logic  push, q_full, q_valid, q_pop;
    item_t push_item, q_item;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register index sits in the word address bit
    always_comb
    begin
        unique case (paddr[2])
            REG_CTM: prdata = ctm_reg;
            REG_TS:  prdata = ts_reg;
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctm_reg <= '0;
            ts_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_CTM: ctm_reg <= pwdata;
                REG_TS:  ts_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    // k = round(ctm * dt / 2), recomputed every cycle; a write reaches k through prod_reg and then k_reg
    assign ksum = 66'(prod_reg) + (66'sd1 <<< 32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            k_reg    <= '0;
        end
        else
        begin
            prod_reg <= $signed(ctm_reg) * $signed({1'b0, ts_reg});
            k_reg    <= sat32(52'($signed(ksum[65:33])));
        end
    end

    bvp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    bvp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_item)
    );

    bvp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .k        (k_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// stream test of the boris velocity push: an in-bench fixed-point predictor
// works out each updated velocity and every output transaction is compared
// against the oldest prediction, under several register settings and idling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import bvp_pkg::*;

    localparam int  LATENCY     = 28;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [2:0] ADDR_CTM = 3'd0;   // charge_to_mass
    localparam logic [2:0] ADDR_TS  = 3'd4;   // time_step

    typedef logic signed [31:0] q_t;
    typedef struct {
        q_t x;
        q_t y;
        q_t z;
    } vel_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // vel_x, vel_y, vel_z, efield_x, efield_y, efield_z, bfield_x, bfield_y, bfield_z
    logic [287:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // new_vel_x, new_vel_y, new_vel_z
    logic [95:0]  m_tdata;

    // predictor copy of the registers
    logic signed [31:0] ctm_reg = '0;
    logic [31:0]        ts_reg  = '0;

    vel_t   pending_vel[$];
    int     mismatches = 0;
    longint cycles = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_off = 0;
    int     hold_req = 0;
    int     hold_ack = 0;

    always #2 clk = ~clk;

    boris_velocity_push DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // ---------------- fixed-point predictor ----------------

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // q16.16 product, round half up; arithmetic shift is a floor
    function automatic longint qprod(longint a, longint b);
        longint p;
        p = a * b + 64'sd32768;
        return p >>> 16;
    endfunction

    // base + a x b, each component clamped
    function automatic void cross_sum(input longint base[3], input longint a[3],
                                      input longint b[3], output longint r[3]);
        r[0] = clamp32(base[0] + qprod(a[1], b[2]) - qprod(a[2], b[1]));
        r[1] = clamp32(base[1] + qprod(a[2], b[0]) - qprod(a[0], b[2]));
        r[2] = clamp32(base[2] + qprod(a[0], b[1]) - qprod(a[1], b[0]));
    endfunction

    function automatic vel_t boris_push(logic [287:0] item);
        longint v[3], e[3], b[3], ek[3], vm[3], t[3], vp[3], s[3], vplus[3];
        logic signed [95:0] kprod;
        longint k, dot, f;
        logic [63:0] d;
        vel_t r;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = longint'($signed(item[32*i +: 32]));
            e[i] = longint'($signed(item[96 + 32*i +: 32]));
            b[i] = longint'($signed(item[192 + 32*i +: 32]));
        end
        // k = ctm * ts / 2, rounded; product needs 64 bits signed plus one
        kprod = 96'(longint'(ctm_reg)) * $signed({64'd0, ts_reg}) + (96'sd1 <<< 32);
        k = clamp32(longint'(kprod >>> 33));
        for (int i = 0; i < 3; i++)
        begin
            ek[i] = clamp32(qprod(e[i], k));
            vm[i] = clamp32(v[i] + ek[i]);
            t[i]  = clamp32(qprod(b[i], k));
        end
        cross_sum(vm, vm, t, vp);
        dot = qprod(t[0], t[0]) + qprod(t[1], t[1]) + qprod(t[2], t[2]);
        d = 64'(dot) + 64'd65536;
        f = longint'(((64'd1 << 33) + d / 2) / d);
        for (int i = 0; i < 3; i++)
            s[i] = clamp32(qprod(t[i], f));
        cross_sum(vm, vp, s, vplus);
        r.x = q_t'(clamp32(vplus[0] + ek[0]));
        r.y = q_t'(clamp32(vplus[1] + ek[1]));
        r.z = q_t'(clamp32(vplus[2] + ek[2]));
        return r;
    endfunction

    // ---------------- cycle limit ----------------

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("boris_velocity_push: mismatch");
            $finish;
        end
    end

    // ---------------- receiver ----------------

    // ready changes on the falling edge; a long hold-off overrides idling
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_off <= 200;
            m_tready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        vel_t exp_v;
        vel_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x = m_tdata[31:0];
            got.y = m_tdata[63:32];
            got.z = m_tdata[95:64];
            if (pending_vel.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                exp_v = pending_vel.pop_front();
                if (got.x !== exp_v.x || got.y !== exp_v.y || got.z !== exp_v.z)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("velocity: expected %h %h %h, got %h %h %h",
                                 exp_v.x, exp_v.y, exp_v.z, got.x, got.y, got.z);
                end
            end
        end
    end

    // ---------------- shared tasks ----------------

    // one transaction on the input stream; prediction taken at acceptance
    // valid stays up into the next call, which drops it only when idling
    task automatic send_particle(logic [287:0] item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do
            @(posedge clk);
        while (!s_tready);
        pending_vel.push_back(boris_push(item));
        @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CTM)
            ctm_reg = value;
        else if (addr == ADDR_TS)
            ts_reg = value;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_vel.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        @(negedge clk);
    endtask

    // random field value: mostly moderate, sometimes any 32-bit pattern
    function automatic logic [31:0] rand_field();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2: return 32'($signed($urandom_range(131072)) - 65536);
            default: return 32'($signed($urandom_range(16777216)) - 8388608);
        endcase
    endfunction

    function automatic logic [287:0] rand_particle();
        logic [287:0] item;
        for (int i = 0; i < 9; i++)
            item[32*i +: 32] = rand_field();
        return item;
    endfunction

    // ---------------- tests ----------------

    // extremes of every field, with k of one quarter, large positive k and large negative k
    task automatic test_directed;
        logic [31:0] edge_vals[6] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000,
                                     32'hffff_ffff, 32'h0001_0000, 32'hffff_0000};
        logic [287:0] item;
        write_reg(ADDR_CTM, 32'h0001_0000);
        write_reg(ADDR_TS, 32'h8000_0000);
        for (int j = 0; j < 6; j++)
            send_particle({9{edge_vals[j]}});
        for (int j = 0; j < 6; j++)
        begin
            item = '0;
            for (int i = 0; i < 9; i++)
                item[32*i +: 32] = edge_vals[(i + j) % 6];
            send_particle(item);
        end
        drain();
        write_reg(ADDR_CTM, 32'h7fff_ffff);
        write_reg(ADDR_TS, 32'hffff_ffff);
        for (int j = 0; j < 6; j++)
            send_particle({9{edge_vals[j]}});
        send_particle(rand_particle());
        drain();
        write_reg(ADDR_CTM, 32'h8000_0000);
        for (int j = 0; j < 5; j++)
            send_particle(rand_particle());
        drain();
    endtask

    // random particles under one register setting
    task automatic test_random(int count, logic [31:0] ctm, logic [31:0] ts);
        write_reg(ADDR_CTM, ctm);
        write_reg(ADDR_TS, ts);
        for (int n = 0; n < count; n++)
            send_particle(rand_particle());
        drain();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure;
        write_reg(ADDR_CTM, 32'h0002_0000);
        write_reg(ADDR_TS, 32'h0400_0000);
        send_idle_pct = 0;
        hold_req++;
        for (int n = 0; n < 60; n++)
            send_particle(rand_particle());
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();

        send_idle_pct = 38;
        recv_idle_pct = 87;
        test_random(300, $urandom(), $urandom());
        test_random(250, 32'h0000_8000, 32'h1000_0000);

        send_idle_pct = 87;
        recv_idle_pct = 38;
        test_random(300, $urandom(), $urandom());
        test_random(250, 32'hfff0_0000, 32'h0100_0000);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(300, $urandom(), $urandom());
        test_random(250, 32'h0000_0000, 32'hffff_ffff);

        test_backpressure();

        send_idle_pct = 20;
        recv_idle_pct = 20;
        test_random(200, 32'h7fff_ffff, $urandom());
        test_random(50, 32'h8000_0000, 32'h0000_0000);

        if (mismatches == 0)
            $display("boris_velocity_push: match");
        else
            $display("boris_velocity_push: mismatch");
        $finish;
    end

endmodule
